// ----- rtl/pncm_pkg.sv -----
// Package for the palette nearest color match block.
// Holds the request codes, field widths and the sample/result structs shared by the top level and the distance unit.
`timescale 1ns / 1ps
`default_nettype none

package pncm_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int CHAN_W              = 8;
    localparam int COLOR_W             = 3 * CHAN_W;
    localparam int SQ_W                = 2 * CHAN_W;
    // 3 * 255 * 255 = 195075 fits in 18 bits
    localparam int DIST_W              = 18;
    localparam int IDX_W_MAX           = 8;

    localparam logic [CHAN_W-1:0] CHAN_KEEP_MASK = 8'hFC;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // One palette entry on its way from the RAM to the distance unit
    typedef struct packed {
        logic                 vld;
        logic                 last;
        logic [IDX_W_MAX-1:0] idx;
    } pncm_sample_t;

    // Outcome of a scan
    typedef struct packed {
        logic                 done;
        logic [IDX_W_MAX-1:0] best_idx;
    } pncm_result_t;

    function automatic logic [COLOR_W-1:0] pack_entry(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        pack_entry = {r & CHAN_KEEP_MASK, g & CHAN_KEEP_MASK, b & CHAN_KEEP_MASK};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/palette_nearest_color_match_top.sv -----
// Top level of the palette nearest color match block.
// Depends on pncm_pkg, pncm_ram and pncm_dist.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a palette of PALETTE_ENTRIES RGB colors (8 bits per channel) in one RAM and
// answers nearest-color queries by squared Euclidean distance. A write request (op = 0)
// stores one entry with the low two bits of each channel cleared; writes to entry_index
// >= PALETTE_ENTRIES are dropped. A query request (op = 1) walks the RAM one entry per
// cycle: one RAM read per entry, then one square stage, one compare stage, the step out
// of the scan state and the load of the output register, which waits while the output
// is stalled. The next request can be taken in the same cycle that the result appears.
// Ties go to the lowest index. Requests are taken only between scans, but a new request
// may be accepted while the previous result still sits in the output register. After
// reset every entry reads as zero: a per-entry valid bit masks the RAM until the entry
// is first written, so no clearing pass runs.

module palette_nearest_color_match_top #(
    parameter int PALETTE_ENTRIES = pncm_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // request channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        op,
    input  wire logic [pncm_pkg::IDX_W_MAX-1:0] entry_index,
    input  wire logic [pncm_pkg::CHAN_W-1:0] red,
    input  wire logic [pncm_pkg::CHAN_W-1:0] green,
    input  wire logic [pncm_pkg::CHAN_W-1:0] blue,
    // result channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [pncm_pkg::IDX_W_MAX-1:0]   best_index
);

    import pncm_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic                   issue_reg, issue_next;
    logic [PALETTE_ENTRIES-1:0] live_reg, live_next;
    logic [COLOR_W-1:0]     query_reg;
    logic                   s1_vld_reg, s1_last_reg, s1_live_reg;
    logic [IDX_W-1:0]       s1_idx_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W_MAX-1:0]   best_index_reg, best_index_next;

    logic                   in_fire;
    logic                   in_range;
    logic                   wr_en;
    logic                   query_start;
    logic                   issue_last;
    logic [COLOR_W-1:0]     ram_rdata;
    logic [COLOR_W-1:0]     entry_color;
    pncm_sample_t           sample;
    pncm_result_t           result;

    // Requests are taken only between scans; the output register decouples the sides.
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_fire     = in_valid && !in_stall;
    assign in_range    = ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
    assign wr_en       = in_fire && (op == OP_WRITE) && in_range;
    assign query_start = in_fire && (op == OP_QUERY);
    assign issue_last  = (cnt_reg == IDX_W'(PALETTE_ENTRIES - 1));

    pncm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (entry_index[IDX_W-1:0]),
        .wdata (pack_entry(red, green, blue)),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    // Entries never written since reset read as black.
    assign entry_color = s1_live_reg ? ram_rdata : '0;

    assign sample.vld  = s1_vld_reg;
    assign sample.last = s1_last_reg;
    assign sample.idx  = IDX_W_MAX'(s1_idx_reg);

    pncm_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (query_start),
        .sample      (sample),
        .entry_color (entry_color),
        .query_color (query_reg),
        .result      (result)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        live_next       = live_reg;
        out_valid_next  = out_valid_reg;
        best_index_next = best_index_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (wr_en)
        begin
            live_next[entry_index[IDX_W-1:0]] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_start)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    issue_next = 1'b1;
                end
            end
            ST_SCAN:
            begin
                // address walk; the pipeline drains behind it
                if (issue_reg)
                begin
                    if (issue_last)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (result.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    best_index_next = result.best_idx;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            live_reg      <= '0;
            s1_vld_reg    <= 1'b0;
            s1_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            live_reg      <= live_next;
            s1_vld_reg    <= issue_reg;
            s1_last_reg   <= issue_reg && issue_last;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            query_reg <= {red, green, blue};
        end
        s1_idx_reg     <= cnt_reg;
        s1_live_reg    <= live_reg[cnt_reg];
        best_index_reg <= best_index_next;
    end

    assign out_valid  = out_valid_reg;
    assign best_index = best_index_reg;

endmodule

`default_nettype wire

// ----- rtl/pncm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pncm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/pncm_dist.sv -----
// Distance unit: squares the channel differences, sums them and keeps the running minimum.
// Depends on pncm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pncm_dist (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire pncm_pkg::pncm_sample_t   sample,
    input  wire logic [pncm_pkg::COLOR_W-1:0] entry_color,
    input  wire logic [pncm_pkg::COLOR_W-1:0] query_color,
    output pncm_pkg::pncm_result_t        result
);

    import pncm_pkg::*;

    logic [CHAN_W-1:0]    d_r, d_g, d_b;
    logic [SQ_W-1:0]      sq_r_reg, sq_g_reg, sq_b_reg;
    pncm_sample_t         s2_reg;
    logic [DIST_W-1:0]    sum_sq;
    logic [DIST_W-1:0]    best_dist_reg, best_dist_next;
    logic [IDX_W_MAX-1:0] best_idx_reg, best_idx_next;
    logic                 done_reg, done_next;

    function automatic logic [CHAN_W-1:0] abs_diff(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        d_r = abs_diff(query_color[3*CHAN_W-1:2*CHAN_W], entry_color[3*CHAN_W-1:2*CHAN_W]);
        d_g = abs_diff(query_color[2*CHAN_W-1:CHAN_W],   entry_color[2*CHAN_W-1:CHAN_W]);
        d_b = abs_diff(query_color[CHAN_W-1:0],          entry_color[CHAN_W-1:0]);
    end

    // square stage
    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQ_W'(d_r) * SQ_W'(d_r);
        sq_g_reg <= SQ_W'(d_g) * SQ_W'(d_g);
        sq_b_reg <= SQ_W'(d_b) * SQ_W'(d_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= sample;
        end
    end

    // sum and compare stage; strict less keeps the lowest index on ties
    always_comb
    begin
        sum_sq         = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        done_next      = 1'b0;
        priority if (start)
        begin
            best_dist_next = '1;
            best_idx_next  = '0;
        end
        else if (s2_reg.vld)
        begin
            if (sum_sq < best_dist_reg)
            begin
                best_dist_next = sum_sq;
                best_idx_next  = s2_reg.idx;
            end
            done_next = s2_reg.last;
        end
        else
        begin
            // no sample this cycle: hold the running minimum
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            done_reg      <= done_next;
        end
    end

    assign result.done     = done_reg;
    assign result.best_idx = best_idx_reg;

endmodule

`default_nettype wire
